/* src/ttps_pkg.sv */
// Package for the transposition table probe/store unit.
// Holds the word types, operation and kind codes, the table entry layout and
// the controller command and status structs. No dependencies.
package ttps_pkg;

  // Default number of table entries.
  localparam int unsigned TABLE_ENTRIES_DEF = 4096;

  // Operation codes of an input word. Code 3 is unused and yields a zero result.
  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Bound kind codes of a stored entry. Code 3 is kept as given and never hits.
  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_UPPER = 2'd1;
  localparam logic [1:0] KIND_LOWER = 2'd2;

  typedef struct packed {
    op_t                operation;
    logic        [63:0] position_key;
    logic        [6:0]  search_depth;
    logic signed [15:0] alpha_bound;
    logic signed [15:0] beta_bound;
    logic signed [15:0] new_score;
    logic        [1:0]  new_kind;
    logic        [15:0] new_move;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] found_score;
    logic               move_valid;
    logic        [15:0] found_move;
  } out_word_t;

  // One table entry as held in memory.
  typedef struct packed {
    logic        [63:0] key;
    logic        [6:0]  depth;
    logic signed [15:0] score;
    logic        [1:0]  kind;
    logic        [15:0] move;
  } entry_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EVAL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // Capture the input word and read its entry.
    logic eval;         // Resolve probe/store on the read entry, emit the result.
    logic sweep_step;   // Zero one entry and advance the sweep counter.
    logic sweep_report; // Emit the all-zero result that ends a clear operation.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_clear;  // The word at the input is a clear operation.
    logic sweep_last;   // The sweep counter points at the last entry.
  } status_t;

endpackage

/* src/transposition_table_probe_store_unit.sv */
// Transposition table probe/store unit, top level.
// Probe, store and the unused operation code read their entry when the word is taken
// and are resolved in the evaluate state; the next word is taken in the cycle the result
// shows, so no word is taken while the last one is still being resolved or written back.
// Clear zeroes one entry per cycle, then shows an all-zero result. After reset the same
// sweep runs with busy high and produces no result.
// Depends on ttps_pkg, ttps_ctrl and ttps_datapath.
module transposition_table_probe_store_unit #(
  parameter int unsigned TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel: a word is taken when start is high and busy is low.
  input  logic                start,
  output logic                busy,
  input  ttps_pkg::in_word_t  in_word,
  // Result channel: each word is valid for exactly the one cycle out_strobe is high.
  output logic                out_strobe,
  output ttps_pkg::out_word_t out_word
);

  // The controller sequences the work; the datapath owns the memory and arithmetic.
  // They talk only through the command and status structs below.
  ttps_pkg::cmd_t    cmd;
  ttps_pkg::status_t status;

  ttps_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath reads the selected entry on the accepting edge, decides the
  // probe or store in the following cycle and registers the result word.
  ttps_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .status     (status),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

endmodule

/* src/ttps_ctrl.sv */
// Controller state machine of the transposition table probe/store unit.
// Depends on ttps_pkg for state, command and status types.
module ttps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ttps_pkg::status_t status,
  output ttps_pkg::cmd_t    cmd,
  output logic              busy
);

  ttps_pkg::state_t state_r, state_nxt;
  logic             report_r, report_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ttps_pkg::ST_SWEEP;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      report_r <= report_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    report_nxt = report_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      ttps_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (status.start_clear) begin
            state_nxt  = ttps_pkg::ST_SWEEP;
            report_nxt = 1'b1;
          end else begin
            state_nxt = ttps_pkg::ST_EVAL;
          end
        end
      end
      ttps_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ttps_pkg::ST_IDLE;
      end
      ttps_pkg::ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          // The sweep after reset ends silently; a clear operation reports.
          cmd.sweep_report = report_r;
          report_nxt       = 1'b0;
          state_nxt        = ttps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ttps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/ttps_datapath.sv */
// Datapath of the transposition table probe/store unit: entry memory,
// input capture, probe/store decision, sweep counter and result register.
// Depends on ttps_pkg for word, entry, command and status types.
module ttps_datapath #(
  parameter int unsigned TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ttps_pkg::in_word_t  in_word,
  input  ttps_pkg::cmd_t      cmd,
  output ttps_pkg::status_t   status,
  output ttps_pkg::out_word_t out_word,
  output logic                out_strobe
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] IDX_MASK = AW'(TABLE_ENTRIES - 1);

  ttps_pkg::entry_t    mem [TABLE_ENTRIES];
  ttps_pkg::entry_t    rd_r;
  ttps_pkg::in_word_t  item_r;
  logic [AW-1:0]       slot_r;
  logic [AW-1:0]       sweep_cnt_r, sweep_cnt_nxt;
  ttps_pkg::out_word_t out_r, out_nxt;
  logic                strobe_r, strobe_nxt;

  logic [AW-1:0]       in_slot;
  logic                we;
  logic [AW-1:0]       wr_addr;
  ttps_pkg::entry_t    wr_data;
  logic                hit_cond;
  logic                exact;
  logic                do_store;

  // Slot index is key AND (entries - 1), which stays inside the table.
  assign in_slot = in_word.position_key[AW-1:0] & IDX_MASK;

  assign status.start_clear = (in_word.operation == ttps_pkg::OP_CLEAR);
  assign status.sweep_last  = (sweep_cnt_r == IDX_MASK);

  // Probe decision on the entry read in the previous cycle.
  always_comb begin
    exact    = 1'b0;
    hit_cond = 1'b0;
    if (rd_r.key == item_r.position_key && rd_r.depth >= item_r.search_depth) begin
      unique case (rd_r.kind)
        ttps_pkg::KIND_EXACT: begin
          exact    = 1'b1;
          hit_cond = 1'b1;
        end
        ttps_pkg::KIND_UPPER: hit_cond = (rd_r.score <= item_r.alpha_bound);
        ttps_pkg::KIND_LOWER: hit_cond = (rd_r.score >= item_r.beta_bound);
        default:              hit_cond = 1'b0;
      endcase
    end
  end

  // Depth-preferred replacement: deeper result or empty slot.
  assign do_store = (item_r.operation == ttps_pkg::OP_STORE) &&
                    ((rd_r.depth < item_r.search_depth) || (rd_r.key == 64'd0));

  always_comb begin
    we      = 1'b0;
    wr_addr = slot_r;
    wr_data = '0;
    if (cmd.sweep_step) begin
      we      = 1'b1;
      wr_addr = sweep_cnt_r;
    end else if (cmd.eval && do_store) begin
      we            = 1'b1;
      wr_data.key   = item_r.position_key;
      wr_data.depth = item_r.search_depth;
      wr_data.score = item_r.new_score;
      wr_data.kind  = item_r.new_kind;
      wr_data.move  = item_r.new_move;
    end
  end

  always_comb begin
    sweep_cnt_nxt = sweep_cnt_r;
    if (cmd.sweep_step) begin
      sweep_cnt_nxt = status.sweep_last ? '0 : sweep_cnt_r + AW'(1);
    end
  end

  always_comb begin
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    if (cmd.eval) begin
      strobe_nxt = 1'b1;
      out_nxt    = '0;
      if (item_r.operation == ttps_pkg::OP_PROBE && hit_cond) begin
        out_nxt.hit         = 1'b1;
        out_nxt.found_score = rd_r.score;
        out_nxt.move_valid  = exact;
        out_nxt.found_move  = exact ? rd_r.move : 16'd0;
      end
    end else if (cmd.sweep_report) begin
      strobe_nxt = 1'b1;
      out_nxt    = '0;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.load) begin
      rd_r <= mem[in_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_word;
      slot_r <= in_slot;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      strobe_r    <= 1'b0;
    end else begin
      sweep_cnt_r <= sweep_cnt_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  assign out_word   = out_r;
  assign out_strobe = strobe_r;

endmodule

/* sim/transposition_table_probe_store_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the transposition table probe/store unit.
// Drives probe, store, clear and unused-code words against a shadow table and checks every
// result word. Depends on ttps_pkg and transposition_table_probe_store_unit.
module transposition_table_probe_store_unit_tb;

  localparam int unsigned TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF;
  // A clear and the sweep after reset each walk every table entry, so the watchdog has
  // to allow several such sweeps before it calls the run hung.
  localparam int unsigned WATCHDOG_LIMIT = 5 * (TABLE_ENTRIES + 64);
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned KEY_POOL_SIZE = 16;
  localparam logic [63:0] SLOT_MASK = 64'(TABLE_ENTRIES - 1);
  // Short local names for the package codes.
  localparam ttps_pkg::op_t OP_PROBE = ttps_pkg::OP_PROBE;
  localparam ttps_pkg::op_t OP_STORE = ttps_pkg::OP_STORE;
  localparam ttps_pkg::op_t OP_CLEAR = ttps_pkg::OP_CLEAR;
  localparam logic [1:0] KIND_EXACT = ttps_pkg::KIND_EXACT;
  localparam logic [1:0] KIND_UPPER = ttps_pkg::KIND_UPPER;
  localparam logic [1:0] KIND_LOWER = ttps_pkg::KIND_LOWER;
  // Codes that the package leaves unnamed.
  localparam ttps_pkg::op_t OP_UNUSED = ttps_pkg::op_t'(2'd3);
  localparam logic [1:0] KIND_INVALID = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ttps_pkg::in_word_t  in_word = '0;
  logic                out_strobe;
  ttps_pkg::out_word_t out_word;

  transposition_table_probe_store_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the table and the result words still owed by the block, oldest first.
  ttps_pkg::entry_t    shadow_entries [TABLE_ENTRIES];
  ttps_pkg::out_word_t awaited_words [$];
  logic [63:0]         key_pool [KEY_POOL_SIZE];

  int unsigned idle_pct = 0;
  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned clears_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_cycles = 0;

  function automatic void wipe_shadow();
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
  endfunction

  // Applies one word to the shadow table and returns the result word it must produce.
  function automatic ttps_pkg::out_word_t apply_table_op(input ttps_pkg::in_word_t w);
    ttps_pkg::out_word_t r;
    ttps_pkg::entry_t    e;
    int unsigned         slot;
    r = '0;
    slot = int'(w.position_key & SLOT_MASK);
    e = shadow_entries[slot];
    case (w.operation)
      OP_PROBE: begin
        // A hit needs the same key and at least the requested depth. Only an exact entry
        // hands back its move; a bound entry must also clear the window edge.
        if (e.key == w.position_key && e.depth >= w.search_depth) begin
          if (e.kind == KIND_EXACT) begin
            r.hit = 1'b1;
            r.found_score = e.score;
            r.move_valid = 1'b1;
            r.found_move = e.move;
          end else if ((e.kind == KIND_UPPER && $signed(e.score) <= $signed(w.alpha_bound)) ||
                       (e.kind == KIND_LOWER && $signed(e.score) >= $signed(w.beta_bound))) begin
            r.hit = 1'b1;
            r.found_score = e.score;
          end
        end
      end
      OP_STORE: begin
        // Deeper results win; a key of zero marks the slot as free.
        if (e.depth < w.search_depth || e.key == '0) begin
          e.key = w.position_key;
          e.depth = w.search_depth;
          e.score = w.new_score;
          e.kind = w.new_kind;
          e.move = w.new_move;
          shadow_entries[slot] = e;
        end
      end
      OP_CLEAR: wipe_shadow();
      default: ;
    endcase
    return r;
  endfunction

  function automatic ttps_pkg::in_word_t make_word(input ttps_pkg::op_t op,
                                                   input logic [63:0] key,
                                                   input logic [6:0] depth,
                                                   input logic signed [15:0] alpha,
                                                   input logic signed [15:0] beta,
                                                   input logic signed [15:0] score,
                                                   input logic [1:0] kind,
                                                   input logic [15:0] move);
    ttps_pkg::in_word_t w;
    w.operation = op;
    w.position_key = key;
    w.search_depth = depth;
    w.alpha_bound = alpha;
    w.beta_bound = beta;
    w.new_score = score;
    w.new_kind = kind;
    w.new_move = move;
    return w;
  endfunction

  // Scores and window edges mostly sit in a narrow band so that bound checks land on
  // both sides and on equality; the rest cover the full 16-bit range.
  function automatic logic signed [15:0] pick_score();
    if ($urandom_range(99) < 80) return 16'(int'($urandom_range(16)) - 8);
    return 16'($urandom());
  endfunction

  function automatic ttps_pkg::in_word_t random_word(input ttps_pkg::op_t op,
                                                     input logic [63:0] key);
    logic [6:0] depth;
    logic [1:0] kind;
    depth = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(15));
    kind = ($urandom_range(9) == 0) ? KIND_INVALID : 2'($urandom_range(2));
    return make_word(op, key, depth, pick_score(), pick_score(), pick_score(), kind,
                     16'($urandom()));
  endfunction

  // Most keys come from a small pool: eight slots with two keys each, so stores are
  // probed again, replaced and hit by colliding keys. The odd key is zero or fully random.
  function automatic logic [63:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    if (r < 90) return '0;
    return {$urandom(), $urandom()};
  endfunction

  function automatic void refill_key_pool();
    logic [63:0] slot_bits;
    for (int i = 0; i < KEY_POOL_SIZE; i += 2) begin
      slot_bits = {$urandom(), $urandom()} & SLOT_MASK;
      key_pool[i] = ({$urandom(), $urandom()} & ~SLOT_MASK) | slot_bits;
      key_pool[i + 1] = ({$urandom(), $urandom()} & ~SLOT_MASK) | slot_bits;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    err_count++;
  endtask

  // Sends one word. The sender may sit idle for a few cycles first; start is then held
  // high until the block takes the word, and left high so the next word can follow
  // without a gap.
  task automatic send_word(input ttps_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      idle_cycles++;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    awaited_words.push_back(apply_table_op(w));
    words_sent++;
    if (w.operation == OP_CLEAR) clears_sent++;
  endtask

  // Each special case of the table, walked through once with known keys.
  task automatic test_directed_cases();
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_d;
    key_a = 64'h0123_4567_89AB_C005;
    key_b = 64'hFEDC_BA98_7654_3005;  // Same slot as key_a.
    key_c = 64'h8000_0000_0000_1000;  // Same slot as key zero.
    key_d = 64'h7FFF_FFFF_FFFF_F7FF;
    // An empty entry looks like key zero at depth zero, exact.
    send_word(make_word(OP_PROBE, '0, 7'd0, 16'sd0, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
    send_word(make_word(OP_PROBE, '0, 7'd1, 16'sd0, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
    send_word(make_word(OP_STORE, key_a, 7'd5, 16'sd0, 16'sd0, 16'sh7FFF, KIND_EXACT,
                        16'hFFFF));
    send_word(make_word(OP_PROBE, key_a, 7'd5, 16'sd0, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
    send_word(make_word(OP_PROBE, key_a, 7'd6, 16'sd0, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
    // A colliding key misses, and a store of equal depth must not evict the entry.
    send_word(make_word(OP_PROBE, key_b, 7'd0, 16'sd0, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
    send_word(make_word(OP_STORE, key_b, 7'd5, 16'sd1, 16'sd1, 16'sd1, KIND_EXACT, 16'h1));
    send_word(make_word(OP_PROBE, key_a, 7'd0, 16'sd0, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
    // A stored key of zero still counts as empty, so a shallower store replaces it.
    send_word(make_word(OP_STORE, '0, 7'd10, 16'sd0, 16'sd0, 16'sh8000, KIND_UPPER,
                        16'h1234));
    send_word(make_word(OP_STORE, key_c, 7'd0, 16'sd0, 16'sd0, 16'sd0, KIND_LOWER, 16'h5678));
    // Lower bound: hits at beta, misses just above it.
    send_word(make_word(OP_PROBE, key_c, 7'd0, 16'sh8000, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
    send_word(make_word(OP_PROBE, key_c, 7'd0, 16'sh8000, 16'sd1, 16'sd0, KIND_EXACT, 16'h0));
    // Upper bound at the deepest depth: hits at alpha without a move, misses just below.
    send_word(make_word(OP_STORE, key_d, 7'd127, 16'sd0, 16'sd0, -16'sd100, KIND_UPPER,
                        16'hABCD));
    send_word(make_word(OP_PROBE, key_d, 7'd127, -16'sd100, 16'sh7FFF, 16'sd0, KIND_EXACT,
                        16'h0));
    send_word(make_word(OP_PROBE, key_d, 7'd127, -16'sd101, 16'sh7FFF, 16'sd0, KIND_EXACT,
                        16'h0));
    // An entry of the unnamed kind never hits, whatever the window.
    send_word(make_word(OP_STORE, '1, 7'd127, 16'sd0, 16'sd0, 16'sh7FFF, KIND_INVALID,
                        16'hFFFF));
    send_word(make_word(OP_PROBE, '1, 7'd0, 16'sh7FFF, 16'sh8000, 16'sd0, KIND_EXACT, 16'h0));
    // The unused operation code with every field at all ones leaves the table alone.
    send_word(make_word(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1));
    send_word(make_word(OP_PROBE, key_a, 7'd0, 16'sd0, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
    // After a clear every slot is empty again.
    send_word(make_word(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0));
    send_word(make_word(OP_PROBE, key_a, 7'd0, 16'sd0, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
    send_word(make_word(OP_PROBE, '0, 7'd0, 16'sd0, 16'sd0, 16'sd0, KIND_EXACT, 16'h0));
  endtask

  // Random traffic at one sender idle rate. A fifth of the draws are a store followed
  // at once by a probe of the same key; clears and the unused code stay rare, and a
  // few probes carry fully random fields as noise.
  task automatic test_random_traffic(input int unsigned n_words, input int unsigned pct);
    int unsigned stop_at;
    int unsigned r;
    logic [63:0] key;
    idle_pct = pct;
    refill_key_pool();
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      r = $urandom_range(99);
      key = pick_key();
      if (r < 20) begin
        send_word(random_word(OP_STORE, key));
        send_word(random_word(OP_PROBE, key));
      end else if (r < 55) begin
        send_word(random_word(OP_PROBE, key));
      end else if (r < 92) begin
        send_word(random_word(OP_STORE, key));
      end else if (r < 94) begin
        send_word(random_word(OP_UNUSED, key));
      end else if (r == 94) begin
        send_word(random_word(OP_CLEAR, key));
      end else begin
        send_word(make_word(OP_PROBE, {$urandom(), $urandom()}, 7'($urandom()),
                            16'($urandom()), 16'($urandom()), 16'($urandom()),
                            2'($urandom()), 16'($urandom())));
      end
    end
  endtask

  // Every strobed result is compared field by field with the oldest word still owed.
  always @(posedge clk) begin : check_results
    ttps_pkg::out_word_t want;
    if (rst_n && out_strobe) begin
      if (awaited_words.size() == 0) begin
        report_mismatch($sformatf("result word %h arrived with nothing awaited", out_word));
      end else begin
        want = awaited_words.pop_front();
        results_checked++;
        if (want.hit) hits_seen++;
        if (out_word.hit !== want.hit)
          report_mismatch($sformatf("hit got %b want %b", out_word.hit, want.hit));
        if (out_word.found_score !== want.found_score)
          report_mismatch($sformatf("found_score got %h want %h", out_word.found_score,
                                    want.found_score));
        if (out_word.move_valid !== want.move_valid)
          report_mismatch($sformatf("move_valid got %b want %b", out_word.move_valid,
                                    want.move_valid));
        if (out_word.found_move !== want.found_move)
          report_mismatch($sformatf("found_move got %h want %h", out_word.found_move,
                                    want.found_move));
      end
    end
  end

  // The watchdog restarts whenever a word moves in either direction.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results still owed",
               WATCHDOG_LIMIT, awaited_words.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wipe_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The block sweeps its table after reset; send_word waits on busy through it.
    test_directed_cases();
    test_random_traffic(270, 0);
    test_random_traffic(270, 77);
    test_random_traffic(260, 10);
    start <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d clears) with %0d sender idle cycles.", words_sent,
             clears_sent, idle_cycles);
    $display("Checked %0d result words, %0d of them probe hits; %0d mismatches.",
             results_checked, hits_seen, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* transposition_table_probe_store_unit.f */
src/ttps_pkg.sv
src/ttps_ctrl.sv
src/ttps_datapath.sv
src/transposition_table_probe_store_unit.sv
sim/transposition_table_probe_store_unit_tb.sv
